/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside of reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescape block.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    ST_RUN     = 4'd0,
    ST_DONE    = 4'd1,
    ST_NOQUOTE = 4'd2,
    ST_CTRL    = 4'd3,
    ST_BADESC  = 4'd4,
    ST_BADHEX  = 4'd5,
    ST_NOPAIR  = 4'd6,
    ST_BADLOW  = 4'd7,
    ST_LONELOW = 4'd8,
    ST_EARLY   = 4'd9
  } status_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;
    logic            tail;
    status_t         status;
  } desc_t;

endpackage

/* hdl/jsu_in_if.sv */
// ----------------------------------------------------------------------------
// jsu_in_if
// Input text byte channel.
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

/* hdl/jsu_out_if.sv */
// ----------------------------------------------------------------------------
// jsu_out_if
// Decoded result channel.
// ----------------------------------------------------------------------------
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [3:0] status;
  logic       last;

  modport source (output valid, output out_byte, output byte_valid, output status,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input status,
                  input last, output ready);
endinterface

/* hdl/json_string_unescape_utf8.sv */
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Byte-serial decoder of one JSON string literal to UTF-8.
// ----------------------------------------------------------------------------
// Usage: din carries one text byte per beat (data_byte, end_of_input). dout
// carries results: a decoded byte (byte_valid 1, status 0) or a status beat
// (byte_valid 0). Every input byte yields one to five result beats, the final
// one marked with last. A byte that decodes nothing and ends nothing yields a
// single empty beat with status 0.
// The decoded descriptor of a byte goes into the queue and from there into
// the output register. Input is taken at one byte per cycle while the queue
// is not full; output runs at one beat per cycle while dout.ready is high.
// A four-entry descriptor queue between the decoder and the output stage
// absorbs that expansion; din.ready drops only while the queue is full.
// Reset clears the decoder to idle (waiting for the opening quote), empties
// the queue and drops dout.valid. When the receiver stalls, the current beat
// holds on dout and the queue fills, after which din is held off.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
  input  logic      clk,
  input  logic      rst,
  jsu_in_if.sink    din,
  jsu_out_if.source dout
);

  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  jsu_pkg::desc_t wr_desc;
  jsu_pkg::desc_t head;

  jsu_front u_front (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .full (full),
    .push (push),
    .desc (wr_desc)
  );

  jsu_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_desc (wr_desc),
    .pop     (pop),
    .head    (head),
    .full    (full),
    .empty   (empty)
  );

  jsu_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .dout  (dout)
  );

endmodule

/* hdl/jsu_front.sv */
// ----------------------------------------------------------------------------
// jsu_front
// Accept text bytes, track the string/escape state and build one result
// descriptor per byte.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic            clk,
  input  logic            rst,
  jsu_in_if.sink          din,
  input  logic            full,
  output logic            push,
  output jsu_pkg::desc_t  desc
);

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CTRL_TOP = 8'h20;

  typedef enum logic [6:0] {
    M_IDLE    = 7'b0000001,
    M_STR     = 7'b0000010,
    M_ESC     = 7'b0000100,
    M_HEX1    = 7'b0001000,
    M_PAIR_BS = 7'b0010000,
    M_PAIR_U  = 7'b0100000,
    M_HEX2    = 7'b1000000
  } mode_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;
  } enc_t;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
    return v;
  endfunction

  function automatic enc_t utf8_enc(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp <= 21'h7F) begin
      e.bytes[0] = cp[7:0];
      e.nbytes   = 3'd1;
    end else if (cp <= 21'h7FF) begin
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
      e.nbytes   = 3'd2;
    end else if (cp <= 21'hFFFF) begin
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
      e.nbytes   = 3'd3;
    end else begin
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
      e.nbytes   = 3'd4;
    end
    return e;
  endfunction

  mode_t       mode, mode_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic [9:0]  high_half, high_half_next;

  logic [7:0]       c;
  logic [4:0]       hv;
  logic [15:0]      acc_shift;
  logic [20:0]      cp;
  enc_t             enc;
  logic             ended;
  jsu_pkg::status_t st;
  logic [3:0][7:0]  bytes;
  logic [2:0]       nb;

  assign c         = din.data_byte;
  assign hv        = hex_value(c);
  assign acc_shift = {hex_accum[11:0], hv[3:0]};
  assign cp        = (mode == M_HEX2) ? 21'(21'h10000 + {1'b0, high_half, acc_shift[9:0]})
                                      : {5'b0, acc_shift};
  assign enc       = utf8_enc(cp);

  always_comb begin
    mode_next      = mode;
    hex_count_next = hex_count;
    hex_accum_next = hex_accum;
    high_half_next = high_half;
    st             = jsu_pkg::ST_RUN;
    ended          = 1'b0;
    bytes          = '0;
    nb             = 3'd0;
    case (mode)
      M_STR: begin
        if (c == CH_QUOTE) begin
          st = jsu_pkg::ST_DONE; ended = 1'b1;
        end else if (c < CTRL_TOP) begin
          st = jsu_pkg::ST_CTRL; ended = 1'b1;
        end else if (c == CH_BSL) begin
          mode_next = M_ESC;
        end else begin
          bytes[0] = c; nb = 3'd1;
        end
      end
      M_ESC: begin
        mode_next = M_STR;
        case (c)
          CH_QUOTE, CH_BSL, CH_SLASH: begin bytes[0] = c;     nb = 3'd1; end
          CH_B:                       begin bytes[0] = 8'h08; nb = 3'd1; end
          CH_F:                       begin bytes[0] = 8'h0C; nb = 3'd1; end
          CH_N:                       begin bytes[0] = 8'h0A; nb = 3'd1; end
          CH_R:                       begin bytes[0] = 8'h0D; nb = 3'd1; end
          CH_T:                       begin bytes[0] = 8'h09; nb = 3'd1; end
          CH_U: begin
            mode_next = M_HEX1; hex_count_next = 2'd0; hex_accum_next = 16'd0;
          end
          default: begin
            st = jsu_pkg::ST_BADESC; ended = 1'b1;
          end
        endcase
      end
      M_HEX1, M_HEX2: begin
        if (hv[4]) begin
          st = jsu_pkg::ST_BADHEX; ended = 1'b1;
        end else begin
          hex_accum_next = acc_shift;
          if (hex_count != 2'd3) begin
            hex_count_next = 2'(hex_count + 2'd1);
          end else begin
            hex_count_next = 2'd0;
            if (mode == M_HEX1) begin
              if (acc_shift[15:10] == 6'b110110) begin
                high_half_next = acc_shift[9:0];
                mode_next      = M_PAIR_BS;
              end else if (acc_shift[15:10] == 6'b110111) begin
                st = jsu_pkg::ST_LONELOW; ended = 1'b1;
              end else begin
                bytes = enc.bytes; nb = enc.nbytes; mode_next = M_STR;
              end
            end else begin
              if (acc_shift[15:10] != 6'b110111) begin
                st = jsu_pkg::ST_BADLOW; ended = 1'b1;
              end else begin
                bytes = enc.bytes; nb = enc.nbytes; mode_next = M_STR;
              end
            end
          end
        end
      end
      M_PAIR_BS: begin
        if (c != CH_BSL) begin
          st = jsu_pkg::ST_NOPAIR; ended = 1'b1;
        end else begin
          mode_next = M_PAIR_U;
        end
      end
      M_PAIR_U: begin
        if (c != CH_U) begin
          st = jsu_pkg::ST_NOPAIR; ended = 1'b1;
        end else begin
          mode_next = M_HEX2; hex_count_next = 2'd0; hex_accum_next = 16'd0;
        end
      end
      default: begin
        if (c == CH_QUOTE) begin
          mode_next = M_STR;
        end else begin
          st = jsu_pkg::ST_NOQUOTE; ended = 1'b1;
        end
      end
    endcase
    if (!ended && din.end_of_input) begin
      st = jsu_pkg::ST_EARLY; ended = 1'b1;
    end
    if (ended) begin
      mode_next      = M_IDLE;
      hex_count_next = 2'd0;
      hex_accum_next = 16'd0;
      high_half_next = 10'd0;
    end
  end

  assign din.ready   = !full;
  assign push        = din.valid && !full;
  assign desc.bytes  = bytes;
  assign desc.nbytes = nb;
  assign desc.tail   = ended || (nb == 3'd0);
  assign desc.status = st;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      hex_count <= 2'd0;
      hex_accum <= 16'd0;
      high_half <= 10'd0;
    end else if (push) begin
      mode      <= mode_next;
      hex_count <= hex_count_next;
      hex_accum <= hex_accum_next;
      high_half <= high_half_next;
    end
  end

endmodule

/* hdl/jsu_queue.sv */
// ----------------------------------------------------------------------------
// jsu_queue
// Short descriptor FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module jsu_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  jsu_pkg::desc_t  wr_desc,
  input  logic            pop,
  output jsu_pkg::desc_t  head,
  output logic            full,
  output logic            empty
);

  jsu_pkg::desc_t              mem [jsu_pkg::QDEPTH];
  logic [jsu_pkg::QAW-1:0]     wr_ptr;
  logic [jsu_pkg::QAW-1:0]     rd_ptr;
  logic [jsu_pkg::QCW-1:0]     count;

  assign full  = (count == jsu_pkg::QCW'(jsu_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= jsu_pkg::QAW'(wr_ptr + 1'b1);
      if (pop)  rd_ptr <= jsu_pkg::QAW'(rd_ptr + 1'b1);
      if (push && !pop) begin
        count <= jsu_pkg::QCW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= jsu_pkg::QCW'(count - 1'b1);
      end
    end
  end

endmodule

/* hdl/jsu_back.sv */
// ----------------------------------------------------------------------------
// jsu_back
// Walk each descriptor and send its decoded bytes, then its closing status
// beat if it has one, one beat per cycle unless dout stalls, through the output register.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic            clk,
  input  logic            rst,
  input  jsu_pkg::desc_t  head,
  input  logic            empty,
  output logic            pop,
  jsu_out_if.source       dout
);

  logic [2:0] k;
  logic [2:0] total;
  logic       at_last;
  logic       is_data;
  logic       load;

  logic       ov;
  logic [7:0] obyte;
  logic       obv;
  logic [3:0] ostat;
  logic       olast;

  assign total   = 3'(head.nbytes + {2'b00, head.tail});
  assign at_last = (k == 3'(total - 3'd1));
  assign is_data = (k < head.nbytes);
  assign load    = !empty && (!ov || dout.ready);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      k  <= 3'd0;
    end else begin
      if (load) begin
        ov <= 1'b1;
        k  <= at_last ? 3'd0 : 3'(k + 3'd1);
      end else if (dout.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      obyte <= is_data ? head.bytes[k[1:0]] : 8'd0;
      obv   <= is_data;
      ostat <= is_data ? jsu_pkg::ST_RUN : head.status;
      olast <= at_last;
    end
  end

  assign dout.valid      = ov;
  assign dout.out_byte   = obyte;
  assign dout.byte_valid = obv;
  assign dout.status     = ostat;
  assign dout.last       = olast;

endmodule

/* hdl/jsu_checker.sv */
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks on the result channel of the string decoder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic [3:0] status,
  input logic       last
);

  `ASSERT_ALWAYS(a_rst_quiet, clk, rst |=> !out_valid, "output valid after reset")
  `ASSERT_CLK(a_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status) && $stable(last), "stalled beat changed")
  `ASSERT_CLK(a_data_run, clk, rst, out_valid && byte_valid |-> status == jsu_pkg::ST_RUN, "data beat with status")
  `ASSERT_CLK(a_status_last, clk, rst, out_valid && status != jsu_pkg::ST_RUN |-> last && !byte_valid && out_byte == 8'd0, "status beat not final")

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (dout.valid),
  .out_ready  (dout.ready),
  .out_byte   (dout.out_byte),
  .byte_valid (dout.byte_valid),
  .status     (dout.status),
  .last       (dout.last)
);

/* dv/json_string_unescape_utf8_tb.sv */
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_tb
// Drives JSON string bytes into the unescape block and checks every UTF-8
// and status beat against a decoder model kept in step with the accepted
// input. Directed strings open the run, then random strings with injected
// faults and idle noise follow, under three idle patterns on both sides.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 200000;
  localparam logic [7:0] QUOTE    = 8'h22;
  localparam logic [7:0] BSLASH   = 8'h5C;
  localparam logic [7:0] LETTER_U = 8'h75;

  typedef enum logic [2:0] {
    P_IDLE, P_STR, P_ESC, P_HEX1, P_PAIR_BS, P_PAIR_U, P_HEX2
  } scan_mode_t;

  typedef struct {
    logic [7:0] data_byte;
    logic       eoi;
    int         phase;
    logic       drain;
  } text_byte_t;

  typedef struct {
    logic [7:0]       out_byte;
    logic             byte_valid;
    jsu_pkg::status_t status;
    logic             last;
  } utf8_beat_t;

  logic clk = 1'b0;
  logic rst;

  jsu_in_if  din ();
  jsu_out_if dout ();

  json_string_unescape_utf8 dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  text_byte_t text_q[$];
  utf8_beat_t utf8_due[$];
  utf8_beat_t step_beats[$];
  utf8_beat_t got_beat;

  int send_idle[3] = '{26, 63, 0};
  int recv_idle[3] = '{63, 26, 0};
  int cur_phase = 0;
  int fill_phase = 0;
  logic drain_next = 1'b0;
  int errors = 0;
  int cycles = 0;

  scan_mode_t scan_mode = P_IDLE;
  logic [1:0]  nib_cnt = '0;
  logic [15:0] hex_word = '0;
  logic [9:0]  hi_bits = '0;

  // ---------------------------------------------------------------- decoder

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
    if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return 5'(c[3:0] + 4'd9);
    return 5'd16;
  endfunction

  function automatic void add_beat(input logic [7:0] b, input logic v,
                                   input jsu_pkg::status_t st);
    utf8_beat_t nb;
    nb = '{out_byte: b, byte_valid: v, status: st, last: 1'b0};
    step_beats.insert(step_beats.size(), nb);
  endfunction

  function automatic void add_utf8(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      add_beat(cp[7:0], 1'b1, jsu_pkg::ST_RUN);
    end else if (cp <= 21'h7FF) begin
      add_beat({3'b110, cp[10:6]}, 1'b1, jsu_pkg::ST_RUN);
      add_beat({2'b10, cp[5:0]}, 1'b1, jsu_pkg::ST_RUN);
    end else if (cp <= 21'hFFFF) begin
      add_beat({4'b1110, cp[15:12]}, 1'b1, jsu_pkg::ST_RUN);
      add_beat({2'b10, cp[11:6]}, 1'b1, jsu_pkg::ST_RUN);
      add_beat({2'b10, cp[5:0]}, 1'b1, jsu_pkg::ST_RUN);
    end else begin
      add_beat({5'b11110, cp[20:18]}, 1'b1, jsu_pkg::ST_RUN);
      add_beat({2'b10, cp[17:12]}, 1'b1, jsu_pkg::ST_RUN);
      add_beat({2'b10, cp[11:6]}, 1'b1, jsu_pkg::ST_RUN);
      add_beat({2'b10, cp[5:0]}, 1'b1, jsu_pkg::ST_RUN);
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] c, input logic eoi);
    jsu_pkg::status_t st;
    logic ended;
    logic [4:0] h;
    st = jsu_pkg::ST_RUN;
    ended = 1'b0;
    step_beats.delete();
    case (scan_mode)
      P_STR: begin
        if (c == QUOTE) begin
          st = jsu_pkg::ST_DONE;
          ended = 1'b1;
        end else if (c < 8'h20) begin
          st = jsu_pkg::ST_CTRL;
          ended = 1'b1;
        end else if (c == BSLASH) begin
          scan_mode = P_ESC;
        end else begin
          add_beat(c, 1'b1, jsu_pkg::ST_RUN);
        end
      end
      P_ESC: begin
        scan_mode = P_STR;
        case (c)
          QUOTE, BSLASH, "/": add_beat(c, 1'b1, jsu_pkg::ST_RUN);
          "b": add_beat(8'h08, 1'b1, jsu_pkg::ST_RUN);
          "f": add_beat(8'h0C, 1'b1, jsu_pkg::ST_RUN);
          "n": add_beat(8'h0A, 1'b1, jsu_pkg::ST_RUN);
          "r": add_beat(8'h0D, 1'b1, jsu_pkg::ST_RUN);
          "t": add_beat(8'h09, 1'b1, jsu_pkg::ST_RUN);
          LETTER_U: begin
            scan_mode = P_HEX1;
            nib_cnt = '0;
            hex_word = '0;
          end
          default: begin
            st = jsu_pkg::ST_BADESC;
            ended = 1'b1;
          end
        endcase
      end
      P_HEX1, P_HEX2: begin
        h = hex_nibble(c);
        if (h[4]) begin
          st = jsu_pkg::ST_BADHEX;
          ended = 1'b1;
        end else begin
          hex_word = {hex_word[11:0], h[3:0]};
          if (nib_cnt != 2'd3) begin
            nib_cnt = nib_cnt + 2'd1;
          end else begin
            nib_cnt = '0;
            if (scan_mode == P_HEX1) begin
              if (hex_word >= 16'hD800 && hex_word <= 16'hDBFF) begin
                hi_bits = hex_word[9:0];
                scan_mode = P_PAIR_BS;
              end else if (hex_word >= 16'hDC00 && hex_word <= 16'hDFFF) begin
                st = jsu_pkg::ST_LONELOW;
                ended = 1'b1;
              end else begin
                add_utf8({5'd0, hex_word});
                scan_mode = P_STR;
              end
            end else if (hex_word < 16'hDC00 || hex_word > 16'hDFFF) begin
              st = jsu_pkg::ST_BADLOW;
              ended = 1'b1;
            end else begin
              add_utf8(21'h10000 + {1'b0, hi_bits, hex_word[9:0]});
              scan_mode = P_STR;
            end
          end
        end
      end
      P_PAIR_BS: begin
        if (c != BSLASH) begin
          st = jsu_pkg::ST_NOPAIR;
          ended = 1'b1;
        end else begin
          scan_mode = P_PAIR_U;
        end
      end
      P_PAIR_U: begin
        if (c != LETTER_U) begin
          st = jsu_pkg::ST_NOPAIR;
          ended = 1'b1;
        end else begin
          scan_mode = P_HEX2;
          nib_cnt = '0;
          hex_word = '0;
        end
      end
      default: begin
        if (c == QUOTE) begin
          scan_mode = P_STR;
        end else begin
          st = jsu_pkg::ST_NOQUOTE;
          ended = 1'b1;
        end
      end
    endcase
    if (!ended && eoi) begin
      st = jsu_pkg::ST_EARLY;
      ended = 1'b1;
    end
    if (ended) begin
      scan_mode = P_IDLE;
      nib_cnt = '0;
      hex_word = '0;
      hi_bits = '0;
      add_beat(8'h00, 1'b0, st);
    end else if (step_beats.size() == 0) begin
      add_beat(8'h00, 1'b0, jsu_pkg::ST_RUN);
    end
    step_beats[step_beats.size() - 1].last = 1'b1;
    foreach (step_beats[i]) utf8_due.insert(utf8_due.size(), step_beats[i]);
  endfunction

  // -------------------------------------------------------------- stimulus

  function automatic void queue_byte(input logic [7:0] b, input logic e = 1'b0);
    text_byte_t tb;
    tb = '{data_byte: b, eoi: e, phase: fill_phase, drain: drain_next};
    text_q.insert(text_q.size(), tb);
    drain_next = 1'b0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(1) ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  function automatic void queue_escape_u(input logic [15:0] w);
    queue_byte(BSLASH);
    queue_byte(LETTER_U);
    for (int i = 3; i >= 0; i--) queue_byte(hex_char(w[4*i +: 4]));
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(8'h20, 8'hFF)); while (b == QUOTE || b == BSLASH);
    return b;
  endfunction

  function automatic logic [15:0] bmp_point();
    logic [15:0] w;
    logic [15:0] edges[8] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                              16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};
    case ($urandom_range(3))
      0: w = 16'($urandom_range(16'h7F));
      1: w = 16'($urandom_range(16'h7FF, 16'h80));
      2: w = edges[$urandom_range(7)];
      default: do w = 16'($urandom); while (w >= 16'hD800 && w <= 16'hDFFF);
    endcase
    return w;
  endfunction

  function automatic void queue_token();
    logic [7:0] escapes[8] = '{QUOTE, BSLASH, "/", "b", "f", "n", "r", "t"};
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      queue_byte(plain_byte());
    end else if (pick < 60) begin
      queue_byte(BSLASH);
      queue_byte(escapes[$urandom_range(7)]);
    end else if (pick < 85) begin
      queue_escape_u(bmp_point());
    end else begin
      queue_escape_u(16'($urandom_range(16'hDBFF, 16'hD800)));
      queue_escape_u(16'($urandom_range(16'hDFFF, 16'hDC00)));
    end
  endfunction

  function automatic void queue_fault();
    logic [7:0] b;
    logic [15:0] w;
    logic [4:0] h;
    case ($urandom_range(7))
      0: queue_byte(8'($urandom_range(8'h1F)));
      1: begin
        queue_byte(BSLASH);
        do b = 8'($urandom);
        while (b inside {QUOTE, BSLASH, "/", "b", "f", "n", "r", "t", LETTER_U});
        queue_byte(b);
      end
      2: begin
        queue_byte(BSLASH);
        queue_byte(LETTER_U);
        repeat ($urandom_range(3)) queue_byte(hex_char(4'($urandom)));
        do begin
          b = 8'($urandom);
          h = hex_nibble(b);
        end while (!h[4]);
        queue_byte(b);
      end
      3: queue_escape_u(16'($urandom_range(16'hDFFF, 16'hDC00)));
      4: begin
        queue_escape_u(16'($urandom_range(16'hDBFF, 16'hD800)));
        do b = 8'($urandom); while (b == BSLASH);
        queue_byte(b);
      end
      5: begin
        queue_escape_u(16'($urandom_range(16'hDBFF, 16'hD800)));
        queue_byte(BSLASH);
        do b = 8'($urandom); while (b == LETTER_U);
        queue_byte(b);
      end
      6: begin
        queue_escape_u(16'($urandom_range(16'hDBFF, 16'hD800)));
        do w = 16'($urandom); while (w >= 16'hDC00 && w <= 16'hDFFF);
        queue_escape_u(w);
      end
      default: queue_byte($urandom_range(1) ? BSLASH : plain_byte(), 1'b1);
    endcase
  endfunction

  function automatic void queue_string();
    int ntok;
    int fault_at;
    ntok = $urandom_range(7);
    fault_at = ($urandom_range(99) < 22) ? $urandom_range(ntok) : -1;
    queue_byte(QUOTE);
    for (int k = 0; k < ntok; k++) begin
      if (k == fault_at) begin
        queue_fault();
        return;
      end
      queue_token();
    end
    if (fault_at == ntok) queue_fault();
    else queue_byte(QUOTE, $urandom_range(3) == 0);
  endfunction

  // ----------------------------------------------------------- driver side

  always @(posedge clk) begin
    if (rst) begin
      din.valid <= 1'b0;
      din.data_byte <= '0;
      din.end_of_input <= 1'b0;
    end else if (!din.valid || din.ready) begin
      if (text_q.size() != 0
          && (!text_q[0].drain || (!din.valid && utf8_due.size() == 0))
          && $urandom_range(99) >= send_idle[text_q[0].phase]) begin
        cur_phase = text_q[0].phase;
        din.valid <= 1'b1;
        din.data_byte <= text_q[0].data_byte;
        din.end_of_input <= text_q[0].eoi;
        void'(text_q.pop_front());
      end else begin
        din.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && din.valid && din.ready) decode_byte(din.data_byte, din.end_of_input);
  end

  // ---------------------------------------------------------- monitor side

  always @(posedge clk) begin
    if (rst) begin
      dout.ready <= 1'b0;
    end else begin
      dout.ready <= ($urandom_range(99) >= recv_idle[cur_phase]);
      if (dout.valid && dout.ready) begin
        if (utf8_due.size() == 0) begin
          $error("result beat with nothing expected: byte %h status %0d",
                 dout.out_byte, dout.status);
          errors++;
        end else begin
          got_beat = utf8_due.pop_front();
          if (dout.out_byte !== got_beat.out_byte) begin
            $error("out_byte: expected %h, got %h", got_beat.out_byte, dout.out_byte);
            errors++;
          end
          if (dout.byte_valid !== got_beat.byte_valid) begin
            $error("byte_valid: expected %b, got %b", got_beat.byte_valid, dout.byte_valid);
            errors++;
          end
          if (dout.status !== got_beat.status) begin
            $error("status: expected %0d, got %0d", got_beat.status, dout.status);
            errors++;
          end
          if (dout.last !== got_beat.last) begin
            $error("last: expected %b, got %b", got_beat.last, dout.last);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ------------------------------------------------------------- sequence

  initial begin
    logic [7:0] b;
    rst = 1'b1;
    din.valid = 1'b0;
    din.data_byte = '0;
    din.end_of_input = 1'b0;
    dout.ready = 1'b0;

    queue_byte(8'h00);
    queue_byte(8'hFF, 1'b1);
    queue_byte(QUOTE, 1'b1);
    queue_byte(QUOTE);
    queue_byte(8'h20);
    queue_byte(8'h7F);
    queue_byte(8'hFF);
    queue_byte(BSLASH);
    queue_byte(LETTER_U);
    queue_byte("D");
    queue_byte("8");
    queue_byte("3");
    queue_byte("d");
    queue_byte(BSLASH);
    queue_byte(LETTER_U);
    queue_byte("d");
    queue_byte("E");
    queue_byte("0");
    queue_byte("0");
    queue_byte(QUOTE, 1'b1);
    queue_byte(QUOTE);
    queue_byte(8'h1F);
    queue_byte(QUOTE);
    queue_byte(BSLASH);
    queue_byte("q");

    for (int ph = 0; ph < 3; ph++) begin
      fill_phase = ph;
      drain_next = (ph > 0);
      while (text_q.size() < 25 + 100 * (ph + 1)) begin
        if ($urandom_range(4) == 0) begin
          repeat ($urandom_range(3, 1)) begin
            do b = 8'($urandom); while (b == QUOTE);
            queue_byte(b, 1'($urandom_range(1)));
          end
        end
        queue_string();
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (text_q.size() != 0 || din.valid || utf8_due.size() != 0);
    repeat (16) @(posedge clk);

    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/jsu_pkg.sv
hdl/jsu_in_if.sv
hdl/jsu_out_if.sv
hdl/jsu_front.sv
hdl/jsu_queue.sv
hdl/jsu_back.sv
hdl/json_string_unescape_utf8.sv
hdl/jsu_checker.sv
dv/json_string_unescape_utf8_tb.sv
